### hdl/png_scanline_unfilter_unit_macros.svh
// assertion macros used by the checker of the png scanline unfilter unit
// depends on nothing; a file that uses PSU_ASSERT must have clk and arst_n in scope
`ifndef PNG_SCANLINE_UNFILTER_UNIT_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_UNIT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define PSU_ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// same, on the usual clk and arst_n
`define PSU_ASSERT(label, prop, msg) \
	`PSU_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

### hdl/psu_pkg.sv
// shared constants and types of the png scanline unfilter unit
// no dependencies; used by the channel interfaces and the top level
package psu_pkg;

	localparam int MAX_LINE_BYTES_DEF = 4096;
	localparam int MAX_BPP_DEF        = 8;

	localparam int BYTE_W     = 8;
	localparam int BPP_W      = 4;
	localparam int LEN_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BPP = 2'd0,
		REG_LEN = 2'd1
	} cfg_reg_t;

	typedef enum logic [BYTE_W-1:0] {
		FILT_NONE  = 8'd0,
		FILT_SUB   = 8'd1,
		FILT_UP    = 8'd2,
		FILT_AVG   = 8'd3,
		FILT_PAETH = 8'd4
	} filter_t;

endpackage

### hdl/psu_if.sv
// valid/ready channel interfaces of the png scanline unfilter unit
// depends on psu_pkg for the payload widths
interface psu_in_if;
	logic                        valid;
	logic                        ready;
	logic [psu_pkg::BYTE_W-1:0]  in_byte;
	logic                        frame_start;

	modport source (output valid, output in_byte, output frame_start, input ready);
	modport sink (input valid, input in_byte, input frame_start, output ready);
endinterface

interface psu_out_if;
	logic                        valid;
	logic                        ready;
	logic [psu_pkg::BYTE_W-1:0]  out_byte;
	logic                        line_end;

	modport source (output valid, output out_byte, output line_end, input ready);
	modport sink (input valid, input out_byte, input line_end, output ready);
endinterface

interface psu_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [psu_pkg::CFG_IDX_W-1:0]   index;
	logic [psu_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/png_scanline_unfilter_unit.sv
// png scanline unfilter: rebuilds none/sub/up/average/paeth filtered bytes
// depends on psu_pkg and the channel interfaces in psu_if.sv
//
// channel     dir   word                          handshake
// in_stream   in    in_byte, frame_start          valid/ready
// out_stream  out   out_byte, line_end            valid/ready
// cfg         in    index, data (bpp, line len)   valid/ready, ready always high
//
// one byte per cycle while out_stream is not stalled; a data byte taken from in_stream
// passes the input stage, where the line store read lands, and then the result register
// before it is offered on out_stream. the filter byte of each line yields no word but
// still passes the input stage. no clearing pass: rows are read only after being written.
// reset (arst_n low) empties both stages and returns to waiting for a filter byte.
// while out_stream stalls with a data byte in the input stage, in_stream.ready drops.
module png_scanline_unfilter_unit #(
	parameter int MAX_LINE_BYTES = psu_pkg::MAX_LINE_BYTES_DEF,
	parameter int MAX_BPP        = psu_pkg::MAX_BPP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	psu_in_if.sink     in_stream,
	psu_out_if.source  out_stream,
	psu_cfg_if.sink    cfg
);

	localparam int BW     = psu_pkg::BYTE_W;
	localparam int IDX_W  = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
	localparam int POS_W  = $clog2(MAX_LINE_BYTES + 1);
	localparam int SLOT_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

	function automatic logic [BW-1:0] paeth(input logic [BW-1:0] a, input logic [BW-1:0] b,
			input logic [BW-1:0] c);
		logic signed [BW+1:0] sa, sb, sc, da, db, dc;
		logic [BW+1:0] pa, pb, pc;
		sa = signed'({2'b00, a});
		sb = signed'({2'b00, b});
		sc = signed'({2'b00, c});
		// distance of estimate a+b-c to each neighbour
		da = sb - sc;
		db = sa - sc;
		dc = sa + sb - sc - sc;
		pa = (da < 0) ? unsigned'(-da) : unsigned'(da);
		pb = (db < 0) ? unsigned'(-db) : unsigned'(db);
		pc = (dc < 0) ? unsigned'(-dc) : unsigned'(dc);
		if (pa <= pb && pa <= pc) begin
			return a;
		end else if (pb <= pc) begin
			return b;
		end else begin
			return c;
		end
	endfunction

	// configuration
	logic [psu_pkg::BPP_W-1:0] bpp_q;
	logic [psu_pkg::LEN_W-1:0] len_q;
	logic [psu_pkg::BPP_W-1:0] bpp_eff;
	logic [POS_W-1:0]          len_eff;
	logic [31:0]               len_w;

	// line tracking at the input
	logic [POS_W-1:0]  pos_q;
	logic [BW-1:0]     filt_q;
	logic              first_row_q;
	logic [SLOT_W-1:0] slot_q;

	logic              in_acc;
	logic              is_filt;
	logic [POS_W-1:0]  idx_full;
	logic [IDX_W-1:0]  idx_cur;
	logic              last_cur;
	logic              left_cur;

	// input stage
	logic              s1_valid;
	logic              data_s1;
	logic [BW-1:0]     byte_s1;
	logic [BW-1:0]     filt_s1;
	logic              first_s1;
	logic              last_s1;
	logic              left_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [BW-1:0]     rd_s1;
	logic              s1_adv;
	logic              wr_en;

	logic [BW-1:0] prior_row [MAX_LINE_BYTES];
	logic [BW-1:0] lhist_q [MAX_BPP];
	logic [BW-1:0] ulhist_q [MAX_BPP];

	logic [SLOT_W:0]   back_w;
	logic [SLOT_W-1:0] back;
	logic [BW-1:0]     left, up, upleft, pred, result;
	logic [BW:0]       avg_sum;

	// result register
	logic          out_valid_q;
	logic [BW-1:0] out_byte_q;
	logic          line_end_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= psu_pkg::BPP_W'(1);
			len_q <= psu_pkg::LEN_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				psu_pkg::REG_BPP: bpp_q <= cfg.data[psu_pkg::BPP_W-1:0];
				psu_pkg::REG_LEN: len_q <= cfg.data[psu_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bpp_q == '0) begin
			bpp_eff = psu_pkg::BPP_W'(1);
		end else if (bpp_q > psu_pkg::BPP_W'(MAX_BPP)) begin
			bpp_eff = psu_pkg::BPP_W'(MAX_BPP);
		end else begin
			bpp_eff = bpp_q;
		end
		len_w = 32'(len_q);
		if (len_w == 32'd0) begin
			len_w = 32'd1;
		end
		if (len_w > 32'(MAX_LINE_BYTES)) begin
			len_w = 32'(MAX_LINE_BYTES);
		end
		len_eff = len_w[POS_W-1:0];
	end

	assign s1_adv          = s1_valid && (!data_s1 || !out_valid_q || out_stream.ready);
	assign in_stream.ready = !s1_valid || s1_adv;
	assign in_acc          = in_stream.valid && in_stream.ready;
	assign is_filt         = (pos_q == '0);
	assign idx_full        = pos_q - POS_W'(1);
	assign idx_cur         = idx_full[IDX_W-1:0];
	// pos is index + 1
	assign last_cur        = (pos_q >= len_eff);
	assign left_cur        = (32'(pos_q) > 32'(bpp_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			filt_q      <= '0;
			first_row_q <= 1'b1;
			slot_q      <= '0;
		end else if (in_acc) begin
			if (is_filt) begin
				filt_q <= in_stream.in_byte;
				if (in_stream.frame_start) begin
					first_row_q <= 1'b1;
				end
				pos_q  <= POS_W'(1);
				slot_q <= '0;
			end else begin
				if (last_cur) begin
					pos_q       <= '0;
					first_row_q <= 1'b0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
				if (slot_q == SLOT_W'(MAX_BPP - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + SLOT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_acc) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1  <= !is_filt;
			byte_s1  <= in_stream.in_byte;
			filt_s1  <= filt_q;
			first_s1 <= first_row_q;
			last_s1  <= last_cur;
			left_s1  <= left_cur;
			idx_s1   <= idx_cur;
			slot_s1  <= slot_q;
		end
	end

	// line store: read at accept, written when the byte leaves the input stage
	assign wr_en = s1_adv && data_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			prior_row[idx_s1] <= result;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !is_filt) begin
			rd_s1 <= prior_row[idx_cur];
		end
	end

	always_comb begin
		back_w = {1'b0, slot_s1} + (SLOT_W+1)'(MAX_BPP) - (SLOT_W+1)'(bpp_eff);
		if (back_w >= (SLOT_W+1)'(MAX_BPP)) begin
			back_w = back_w - (SLOT_W+1)'(MAX_BPP);
		end
		back   = back_w[SLOT_W-1:0];
		left   = left_s1 ? lhist_q[back] : '0;
		up     = first_s1 ? '0 : rd_s1;
		upleft = (left_s1 && !first_s1) ? ulhist_q[back] : '0;
		avg_sum = {1'b0, left} + {1'b0, up};
		case (filt_s1)
			psu_pkg::FILT_SUB:   pred = left;
			psu_pkg::FILT_UP:    pred = up;
			psu_pkg::FILT_AVG:   pred = avg_sum[BW:1];
			psu_pkg::FILT_PAETH: pred = paeth(left, up, upleft);
			default:             pred = '0;
		endcase
		result = byte_s1 + pred;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lhist_q[slot_s1]  <= result;
			ulhist_q[slot_s1] <= up;
			out_byte_q        <= result;
			line_end_q        <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_en) begin
			out_valid_q <= 1'b1;
		end else if (out_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_stream.valid    = out_valid_q;
	assign out_stream.out_byte = out_byte_q;
	assign out_stream.line_end = line_end_q;

endmodule

### hdl/psu_checker.sv
// port-level checks of the png scanline unfilter unit, bound to its top level
// depends on png_scanline_unfilter_unit_macros.svh and the top level's ports
`include "png_scanline_unfilter_unit_macros.svh"

module psu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       line_end
);

	// a stalled word holds
	property p_out_hold;
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(line_end);
	endproperty

	// input only waits when the output is stalled
	property p_in_ready;
		!(out_valid && !out_ready) |-> in_ready;
	endproperty

	// a fresh word comes from a byte taken in through the input stage and the result register
	property p_out_cause;
		$rose(out_valid) |-> $past(in_valid && in_ready, 2);
	endproperty

	`PSU_ASSERT(a_out_hold, p_out_hold, "stalled output word changed")
	`PSU_ASSERT(a_in_ready, p_in_ready, "input blocked without output stall")
	`PSU_ASSERT(a_out_cause, p_out_cause, "output word without matching input")

endmodule

bind png_scanline_unfilter_unit psu_checker u_psu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_stream.valid),
	.in_ready  (in_stream.ready),
	.out_valid (out_stream.valid),
	.out_ready (out_stream.ready),
	.out_byte  (out_stream.out_byte),
	.line_end  (out_stream.line_end)
);

### sim/tb_png_scanline_unfilter_unit.sv
// self-checking testbench of png_scanline_unfilter_unit: drives filtered scanlines,
// rebuilds every byte in a scoreboard of its own and compares each output word
// depends on psu_pkg and the channel interfaces in hdl/psu_if.sv
module tb_png_scanline_unfilter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BYTE_W             = psu_pkg::BYTE_W;
	localparam int BPP_W              = psu_pkg::BPP_W;
	localparam int LEN_W              = psu_pkg::LEN_W;
	localparam int CFG_IDX_W          = psu_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W         = psu_pkg::CFG_DATA_W;
	localparam int MAX_LINE_BYTES_DEF = psu_pkg::MAX_LINE_BYTES_DEF;
	localparam int MAX_BPP_DEF        = psu_pkg::MAX_BPP_DEF;

	localparam int unsigned IDLE_LIMIT   = 5000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned SETTLE       = 4;
	localparam int unsigned RANDOM_WORDS = 1400;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic [BYTE_W-1:0] FILT_UNKNOWN_TOP = 8'hFF;

	typedef struct {
		logic [BYTE_W-1:0] out_byte;
		logic              line_end;
	} raw_word_t;

	class unfilter_scoreboard;
		logic [BYTE_W-1:0] prior_row [MAX_LINE_BYTES_DEF];
		logic [BYTE_W-1:0] left_hist [MAX_BPP_DEF];
		logic [BYTE_W-1:0] upleft_hist [MAX_BPP_DEF];
		logic [BYTE_W-1:0] filt;
		logic [BPP_W-1:0]  bpp;
		logic [LEN_W-1:0]  len;
		int unsigned       pos;
		int unsigned       extent;
		bit                first_row;
		raw_word_t         expected [$];
		int unsigned       errors;

		function new();
			foreach (prior_row[i]) prior_row[i] = '0;
			foreach (left_hist[i]) begin
				left_hist[i] = '0;
				upleft_hist[i] = '0;
			end
			filt = psu_pkg::FILT_NONE;
			bpp = BPP_W'(1);
			len = LEN_W'(1);
			pos = 0;
			extent = 0;
			first_row = 1;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] index,
				logic [CFG_DATA_W-1:0] data);
			if (index == psu_pkg::REG_BPP)
				bpp = data[BPP_W-1:0];
			else if (index == psu_pkg::REG_LEN)
				len = data[LEN_W-1:0];
		endfunction

		function int unsigned eff_bpp();
			if (bpp == 0)
				return 1;
			if (bpp > MAX_BPP_DEF)
				return MAX_BPP_DEF;
			return bpp;
		endfunction

		function int unsigned eff_len(logic [LEN_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > MAX_LINE_BYTES_DEF)
				return MAX_LINE_BYTES_DEF;
			return v;
		endfunction

		function int paeth_pick(int a, int b, int c);
			int est, da, db, dc;
			est = a + b - c;
			da = (est > a) ? est - a : a - est;
			db = (est > b) ? est - b : b - est;
			dc = (est > c) ? est - c : c - est;
			if (da <= db && da <= dc)
				return a;
			if (db <= dc)
				return b;
			return c;
		endfunction

		function int unsigned pending();
			return expected.size();
		endfunction

		function void note_input(logic [BYTE_W-1:0] b, logic fs);
			int unsigned idx, slot, back, step;
			int left, up, upleft, pred;
			bit has_left, last;
			raw_word_t w;
			if (pos == 0) begin
				filt = b;
				if (fs)
					first_row = 1;
				pos = 1;
				return;
			end
			step = eff_bpp();
			idx = pos - 1;
			if (idx >= MAX_LINE_BYTES_DEF)
				idx = MAX_LINE_BYTES_DEF - 1;
			slot = idx % MAX_BPP_DEF;
			back = (idx + MAX_BPP_DEF - step) % MAX_BPP_DEF;
			has_left = idx >= step;
			left = has_left ? int'(left_hist[back]) : 0;
			up = first_row ? 0 : int'(prior_row[idx]);
			upleft = (has_left && !first_row) ? int'(upleft_hist[back]) : 0;
			case (filt)
				psu_pkg::FILT_SUB:   pred = left;
				psu_pkg::FILT_UP:    pred = up;
				psu_pkg::FILT_AVG:   pred = (left + up) / 2;
				psu_pkg::FILT_PAETH: pred = paeth_pick(left, up, upleft);
				default:             pred = 0;
			endcase
			w.out_byte = 8'(int'(b) + pred);
			upleft_hist[slot] = 8'(up);
			left_hist[slot] = w.out_byte;
			prior_row[idx] = w.out_byte;
			if (idx + 1 > extent)
				extent = idx + 1;
			last = idx + 1 >= eff_len(len);
			if (last) begin
				pos = 0;
				first_row = 0;
			end else begin
				pos = idx + 2;
			end
			w.line_end = last;
			expected.push_back(w);
		endfunction

		function void check_word(logic [BYTE_W-1:0] out_byte, logic line_end);
			raw_word_t w;
			if (expected.size() == 0) begin
				$error("unexpected word: out_byte %0h line_end %0b", out_byte, line_end);
				errors++;
				return;
			end
			w = expected.pop_front();
			if (out_byte !== w.out_byte) begin
				$error("out_byte: expected %0h, actual %0h", w.out_byte, out_byte);
				errors++;
			end
			if (line_end !== w.line_end) begin
				$error("line_end: expected %0b, actual %0b", w.line_end, line_end);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	psu_in_if  in_if ();
	psu_out_if out_if ();
	psu_cfg_if cfg_if ();

	unfilter_scoreboard sb = new();

	// knobs of the current phase
	int unsigned gap_pct = 0;
	int unsigned fs_noise_pct = 0;
	bit narrow_data = 0;
	bit hold_off_req = 0;
	int unsigned idle_cycles = 0;

	png_scanline_unfilter_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_stream (in_if),
		.out_stream(out_if),
		.cfg       (cfg_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("tb_png_scanline_unfilter_unit: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// output side: checks each word and stalls on its own pattern
	initial begin : receiver
		int unsigned mode, mode_left, hold_left;
		out_if.ready = 1'b0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_if.valid && out_if.ready)
				sb.check_word(out_if.out_byte, out_if.line_end);
			if (hold_off_req) begin
				hold_off_req = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					0: out_if.ready <= 1'b1;
					1: out_if.ready <= 1'($urandom_range(0, 1));
					2: out_if.ready <= ($urandom_range(0, 3) == 0);
					default: out_if.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic send_word(input logic [BYTE_W-1:0] b, input logic fs);
		in_if.valid <= 1'b1;
		in_if.in_byte <= b;
		in_if.frame_start <= fs;
		do @(posedge clk); while (in_if.ready !== 1'b1);
		sb.note_input(b, fs);
	endtask

	task automatic send_line(input logic [BYTE_W-1:0] f, input logic fs,
			input logic [BYTE_W-1:0] data [$]);
		send_word(f, fs);
		foreach (data[i])
			send_word(data[i], 1'b0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= index;
		cfg_if.data <= data;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		sb.set_reg(index, data);
	endtask

	// wait until every expected word is out and the input stage has emptied
	task automatic settle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic void next_word(output logic [BYTE_W-1:0] b, output logic fs);
		if (sb.pos == 0) begin
			if ($urandom_range(0, 9) == 0)
				b = 8'($urandom);
			else
				b = 8'($urandom_range(psu_pkg::FILT_NONE, psu_pkg::FILT_PAETH));
			// a row longer than anything stored must start a new frame
			fs = ($urandom_range(0, 15) == 0) ||
				(!sb.first_row && sb.eff_len(sb.len) > sb.extent);
		end else begin
			if (narrow_data) begin
				case ($urandom_range(0, 5))
					0: b = 8'h00;
					1: b = 8'h01;
					2: b = 8'h7F;
					3: b = 8'h80;
					4: b = 8'hFE;
					default: b = 8'hFF;
				endcase
			end else if ($urandom_range(0, 7) == 0) begin
				b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end else begin
				b = 8'($urandom);
			end
			fs = ($urandom_range(0, 99) < fs_noise_pct);
		end
	endfunction

	task automatic run_stream(input int unsigned count);
		int unsigned burst;
		logic [BYTE_W-1:0] b;
		logic fs;
		while (count != 0) begin
			burst = $urandom_range(1, 32);
			while (burst != 0 && count != 0) begin
				next_word(b, fs);
				send_word(b, fs);
				burst--;
				count--;
			end
			if ($urandom_range(0, 99) < gap_pct) begin
				in_if.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		in_if.valid <= 1'b0;
	endtask

	task automatic finish_line();
		logic [BYTE_W-1:0] b;
		logic fs;
		while (sb.pos != 0) begin
			next_word(b, fs);
			send_word(b, fs);
		end
		in_if.valid <= 1'b0;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_len();
		case ($urandom_range(0, 11))
			0: return CFG_DATA_W'(0);
			1: return CFG_DATA_W'(1);
			2: return CFG_DATA_W'(2);
			3, 4: return CFG_DATA_W'($urandom_range(3, 12));
			default: return CFG_DATA_W'($urandom_range(1, 48));
		endcase
	endfunction

	task automatic configure(input logic [CFG_DATA_W-1:0] len_word);
		logic [CFG_DATA_W-1:0] bpp_word;
		int unsigned order;
		settle();
		case ($urandom_range(0, 9))
			0: bpp_word = '0;
			1: bpp_word = CFG_DATA_W'(1);
			2: bpp_word = CFG_DATA_W'(MAX_BPP_DEF);
			3: bpp_word = CFG_DATA_W'((1 << BPP_W) - 1);
			4: bpp_word = CFG_DATA_W'($urandom);
			default: bpp_word = CFG_DATA_W'($urandom_range(1, MAX_BPP_DEF));
		endcase
		// growing a row mid-line must not reach store entries never written
		if (sb.pos != 0 && !sb.first_row && sb.eff_len(len_word[LEN_W-1:0]) > sb.extent)
			len_word = CFG_DATA_W'(sb.extent);
		order = $urandom_range(0, 7);
		if (order == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
				CFG_DATA_W'($urandom));
		if (order[0]) begin
			write_reg(psu_pkg::REG_BPP, bpp_word);
			write_reg(psu_pkg::REG_LEN, len_word);
		end else begin
			write_reg(psu_pkg::REG_LEN, len_word);
			if (order != 2)
				write_reg(psu_pkg::REG_BPP, bpp_word);
		end
		cfg_if.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned words, chunk, phase;
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.in_byte = '0;
		in_if.frame_start = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = psu_pkg::REG_BPP;
		cfg_if.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pixel size and line length below range, one-byte lines
		write_reg(psu_pkg::REG_BPP, CFG_DATA_W'(0));
		write_reg(psu_pkg::REG_LEN, CFG_DATA_W'(0));
		cfg_if.valid <= 1'b0;
		send_line(psu_pkg::FILT_NONE, 1'b1, '{8'hFF});
		send_line(psu_pkg::FILT_SUB, 1'b0, '{8'h00});
		in_if.valid <= 1'b0;
		settle();

		// first row paeth, then average with a stray frame start, then up
		write_reg(psu_pkg::REG_BPP, CFG_DATA_W'(2));
		write_reg(psu_pkg::REG_LEN, CFG_DATA_W'(4));
		cfg_if.valid <= 1'b0;
		send_line(psu_pkg::FILT_PAETH, 1'b1, '{8'hFF, 8'h80, 8'h01, 8'h7F});
		send_word(psu_pkg::FILT_AVG, 1'b0);
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b0);
		send_word(8'h55, 1'b0);
		send_word(8'hAA, 1'b0);
		send_line(psu_pkg::FILT_UP, 1'b0, '{8'h01, 8'h02, 8'h03, 8'h04});
		// unknown filter, then the line is cut short mid-way
		send_line(FILT_UNKNOWN_TOP, 1'b0, '{8'h12, 8'h34});
		in_if.valid <= 1'b0;
		settle();
		write_reg(psu_pkg::REG_LEN, CFG_DATA_W'(1));
		cfg_if.valid <= 1'b0;
		send_word(8'h56, 1'b0);
		in_if.valid <= 1'b0;

		words = 0;
		phase = 0;
		while (words < RANDOM_WORDS) begin
			configure(pick_len());
			gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
			narrow_data = ($urandom_range(0, 3) == 0);
			fs_noise_pct = $urandom_range(0, 15);
			chunk = $urandom_range(20, 120);
			if (phase == 2) begin
				// receiver holds off while the sender keeps offering words
				gap_pct = 0;
				hold_off_req = 1;
				run_stream(chunk);
			end else if (phase == 4) begin
				run_stream(chunk / 2);
				settle();
				run_stream(chunk - chunk / 2);
			end else begin
				run_stream(chunk);
			end
			words += chunk;
			phase++;
			if (phase == 6) begin
				// length above range, later cut short mid-line
				finish_line();
				configure('1);
				gap_pct = 10;
				run_stream(60);
				words += 60;
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_png_scanline_unfilter_unit: PASS");
		else
			$display("tb_png_scanline_unfilter_unit: FAIL");
		$finish;
	end

endmodule
